// ----- hw/rtl/session_table_with_replay_guard_assert.svh -----
// Assertion macros shared by the session table RTL.
// Each macro expects signals named clk and rst in the enclosing scope.
`ifndef SESSION_TABLE_WITH_REPLAY_GUARD_ASSERT_SVH
`define SESSION_TABLE_WITH_REPLAY_GUARD_ASSERT_SVH

// Same-cycle implication.
`define STG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("session table assertion failed");

// Next-cycle implication.
`define STG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("session table assertion failed");

`endif

// ----- hw/rtl/stg_pkg.sv -----
// ----------------------------------------------------------------------------
// stg_pkg
// Types, codes and small arithmetic helpers of the session table.
// ----------------------------------------------------------------------------
package stg_pkg;

  localparam logic [1:0] OP_JOIN = 2'd0;
  localparam logic [1:0] OP_MOVE = 2'd1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SKEW      = 3'd1;
  localparam logic [2:0] ST_REPLAY    = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_UNKNOWN   = 3'd4;
  localparam logic [2:0] ST_STALE     = 3'd5;
  localparam logic [2:0] ST_BAD_MOVE  = 3'd6;

  localparam logic [1:0] REG_SKEW  = 2'd0;
  localparam logic [1:0] REG_TTL   = 2'd1;
  localparam logic [1:0] REG_LIMIT = 2'd2;

  localparam logic [31:0] SKEW_RESET  = 32'd30000;
  localparam logic [31:0] TTL_RESET   = 32'd1800000;
  localparam logic [14:0] LIMIT_RESET = 15'd10000;

  typedef struct packed {
    logic        valid;
    logic [63:0] tok_hi;
    logic [63:0] tok_lo;
    logic [47:0] expiry;
    logic [63:0] last_seq;
    logic [15:0] x;
    logic [15:0] y;
  } sess_ent_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [47:0] expiry;
  } nonce_ent_t;

  // now plus a lifetime, saturated to 48 bits.
  function automatic logic [47:0] add_sat48(input logic [47:0] a, input logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
  endfunction

  function automatic logic [15:0] clamp_step(input logic [15:0] p, input logic [7:0] d,
                                             input logic [14:0] lim);
    logic signed [16:0] v;
    logic signed [16:0] l;
    v = 17'(signed'(p)) + 17'(signed'(d));
    l = signed'({2'b00, lim});
    if (v < -l) v = -l;
    if (v > l) v = l;
    return v[15:0];
  endfunction

endpackage

// ----- hw/rtl/stg_ram.sv -----
// ----------------------------------------------------------------------------
// stg_ram
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module stg_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/session_table_with_replay_guard.sv -----
// ----------------------------------------------------------------------------
// session_table_with_replay_guard
// Session table keyed by 128-bit tokens with a nonce replay ring.
//
// Channel  Dir  Handshake          Contents
// s_*      in   tvalid/tready      tuser opcode, tdata request fields
// m_*      out  tvalid/tready      tuser status, tdata result fields
// cfg_*    in   cfg_valid/ready    cfg_index register, cfg_data value
//
// After reset a clearing pass over max(SESSIONS, NONCES) addresses zeroes both
// memories; no request beat is taken meanwhile.
// A join scans the nonce ring and then the session memory, a move or a lookup
// scans the session memory: one compare unit walks the memory read port, one
// entry per cycle. A finished result waits in the output register while the
// next beat is taken.
// ----------------------------------------------------------------------------
`include "session_table_with_replay_guard_assert.svh"

module session_table_with_replay_guard #(
  parameter int SESSIONS = 256,
  parameter int NONCES   = 512
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // now_ms, join_time_ms, nonce_hi, nonce_lo, token_hi, token_lo,
  // sequence_req, move_x, move_y
  input  logic [431:0] s_tdata,
  // opcode
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // session_slot, pos_x, pos_y, expires_at_ms
  output logic [87:0]  m_tdata,
  // status
  output logic [2:0]   m_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int SW   = $clog2(SESSIONS);
  localparam int NW   = $clog2(NONCES);
  localparam int IW   = (SW > NW) ? SW : NW;
  localparam int MAXD = (SESSIONS > NONCES) ? SESSIONS : NONCES;
  localparam int MW   = $clog2(MAXD);
  localparam int SBW  = $bits(stg_pkg::sess_ent_t);
  localparam int NBW  = $bits(stg_pkg::nonce_ent_t);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_NSCAN, S_NWRITE, S_SSCAN, S_SWRITE,
    S_FSCAN, S_MOVE, S_DONE
  } state_t;

  state_t state;

  logic [31:0] skew, ttl;
  logic [14:0] limit;

  logic [1:0]  op;
  logic [47:0] now, jt;
  logic [63:0] n_hi, n_lo, t_hi, t_lo, seq;
  logic [7:0]  mx, my;

  logic [MW-1:0] clr;
  logic [IW-1:0] scan_idx, scan_cnt, rd_slot;
  logic          rd_pend, rd_last;
  logic [SW-1:0] s_cursor, slot;
  logic [NW-1:0] n_cursor;
  stg_pkg::sess_ent_t ent;

  logic [2:0]  res_status;
  logic [87:0] res_data;

  logic             s_we, n_we;
  logic [SW-1:0]    s_waddr;
  logic [NW-1:0]    n_waddr;
  logic [SBW-1:0]   s_wdata, s_rdata;
  logic [NBW-1:0]   n_wdata, n_rdata;
  stg_pkg::sess_ent_t  s_q, s_new;
  stg_pkg::nonce_ent_t n_q, n_new;

  logic [47:0] exp_ttl, exp_skew, lo_b;
  logic [48:0] hi_b;
  logic        skew_bad, bad_step, seq_ok;
  logic        n_hit, free_hit, tok_hit;
  logic [IW-1:0] wrap_lim, idx_inc;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  assign s_q = stg_pkg::sess_ent_t'(s_rdata);
  assign n_q = stg_pkg::nonce_ent_t'(n_rdata);

  assign exp_ttl  = stg_pkg::add_sat48(now, ttl);
  assign exp_skew = stg_pkg::add_sat48(now, skew);
  assign lo_b     = (now >= {16'd0, skew}) ? now - {16'd0, skew} : 48'd0;
  assign hi_b     = {1'b0, now} + {17'd0, skew};
  assign skew_bad = (jt < lo_b) || ({1'b0, jt} > hi_b);

  assign n_hit    = n_q.valid && (n_q.expiry > now) && (n_q.hi == n_hi) && (n_q.lo == n_lo);
  assign free_hit = !s_q.valid || (s_q.expiry <= now);
  assign tok_hit  = s_q.valid && (s_q.expiry > now) && (s_q.tok_hi == t_hi) &&
                    (s_q.tok_lo == t_lo);

  assign seq_ok   = seq > ent.last_seq;
  assign bad_step = (signed'(mx) < -8'sd1) || (signed'(mx) > 8'sd1) ||
                    (signed'(my) < -8'sd1) || (signed'(my) > 8'sd1);

  assign wrap_lim = (state == S_NSCAN) ? IW'(NONCES - 1) : IW'(SESSIONS - 1);
  assign idx_inc  = (scan_idx == wrap_lim) ? '0 : scan_idx + 1'b1;

  // Memory write ports.
  always_comb begin
    s_new = '0;
    n_new = '0;
    s_we = 1'b0;
    n_we = 1'b0;
    s_waddr = slot;
    n_waddr = n_cursor;
    case (state)
      S_CLEAR: begin
        s_we = ({1'b0, clr} < (MW+1)'(SESSIONS));
        n_we = ({1'b0, clr} < (MW+1)'(NONCES));
        s_waddr = clr[SW-1:0];
        n_waddr = clr[NW-1:0];
      end
      S_NWRITE: begin
        n_we = 1'b1;
        n_new.valid = 1'b1;
        n_new.hi = n_hi;
        n_new.lo = n_lo;
        n_new.expiry = exp_skew;
      end
      S_SWRITE: begin
        s_we = 1'b1;
        s_new.valid = 1'b1;
        s_new.tok_hi = t_hi;
        s_new.tok_lo = t_lo;
        s_new.expiry = exp_ttl;
      end
      S_MOVE: begin
        s_we = seq_ok;
        s_new = ent;
        s_new.last_seq = seq;
        s_new.expiry = exp_ttl;
        if (!bad_step) begin
          s_new.x = stg_pkg::clamp_step(ent.x, mx, limit);
          s_new.y = stg_pkg::clamp_step(ent.y, my, limit);
        end
      end
      default: begin
      end
    endcase
    s_wdata = s_new;
    n_wdata = n_new;
  end

  stg_ram #(.DEPTH(SESSIONS), .WIDTH(SBW)) u_sess (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(scan_idx[SW-1:0]), .rdata(s_rdata)
  );

  stg_ram #(.DEPTH(NONCES), .WIDTH(NBW)) u_nonce (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(scan_idx[NW-1:0]), .rdata(n_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      skew <= stg_pkg::SKEW_RESET;
      ttl <= stg_pkg::TTL_RESET;
      limit <= stg_pkg::LIMIT_RESET;
      s_cursor <= '0;
      n_cursor <= '0;
      m_tvalid <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          stg_pkg::REG_SKEW:  skew <= cfg_data;
          stg_pkg::REG_TTL:   ttl <= cfg_data;
          stg_pkg::REG_LIMIT: limit <= cfg_data[14:0];
          default: begin
          end
        endcase
      end
      if (state == S_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      // The scan walks one entry per cycle; data of the previous address is
      // judged while the next address is issued.
      if (state == S_NSCAN || state == S_SSCAN || state == S_FSCAN) begin
        rd_pend <= 1'b1;
        rd_slot <= scan_idx;
        rd_last <= (scan_cnt == wrap_lim);
        scan_idx <= idx_inc;
        scan_cnt <= scan_cnt + 1'b1;
      end

      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == MW'(MAXD - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            op <= s_tuser;
            now <= s_tdata[47:0];
            jt <= s_tdata[95:48];
            n_hi <= s_tdata[159:96];
            n_lo <= s_tdata[223:160];
            t_hi <= s_tdata[287:224];
            t_lo <= s_tdata[351:288];
            seq <= s_tdata[415:352];
            mx <= s_tdata[423:416];
            my <= s_tdata[431:424];
            scan_idx <= '0;
            scan_cnt <= '0;
            rd_pend <= 1'b0;
            state <= (s_tuser == stg_pkg::OP_JOIN) ? S_CHECK : S_FSCAN;
          end
        end
        S_CHECK: begin
          if (skew_bad) begin
            res_status <= stg_pkg::ST_SKEW;
            res_data <= '0;
            state <= S_DONE;
          end else begin
            state <= S_NSCAN;
          end
        end
        S_NSCAN: begin
          if (rd_pend && n_hit) begin
            res_status <= stg_pkg::ST_REPLAY;
            res_data <= '0;
            state <= S_DONE;
          end else if (rd_pend && rd_last) begin
            state <= S_NWRITE;
          end
        end
        S_NWRITE: begin
          n_cursor <= (n_cursor == NW'(NONCES - 1)) ? '0 : n_cursor + 1'b1;
          scan_idx <= IW'(s_cursor);
          scan_cnt <= '0;
          rd_pend <= 1'b0;
          state <= S_SSCAN;
        end
        S_SSCAN: begin
          if (rd_pend && free_hit) begin
            slot <= rd_slot[SW-1:0];
            state <= S_SWRITE;
          end else if (rd_pend && rd_last) begin
            res_status <= stg_pkg::ST_FULL;
            res_data <= '0;
            state <= S_DONE;
          end
        end
        S_SWRITE: begin
          s_cursor <= (slot == SW'(SESSIONS - 1)) ? '0 : slot + 1'b1;
          res_status <= stg_pkg::ST_OK;
          res_data <= {exp_ttl, 16'd0, 16'd0, 8'(slot)};
          state <= S_DONE;
        end
        S_FSCAN: begin
          if (rd_pend && tok_hit) begin
            slot <= rd_slot[SW-1:0];
            ent <= s_q;
            if (op == stg_pkg::OP_MOVE) begin
              state <= S_MOVE;
            end else begin
              res_status <= stg_pkg::ST_OK;
              res_data <= {s_q.expiry, s_q.y, s_q.x, 8'(rd_slot)};
              state <= S_DONE;
            end
          end else if (rd_pend && rd_last) begin
            res_status <= stg_pkg::ST_UNKNOWN;
            res_data <= '0;
            state <= S_DONE;
          end
        end
        S_MOVE: begin
          if (!seq_ok) begin
            res_status <= stg_pkg::ST_STALE;
            res_data <= {ent.expiry, ent.y, ent.x, 8'(slot)};
          end else begin
            res_status <= bad_step ? stg_pkg::ST_BAD_MOVE : stg_pkg::ST_OK;
            res_data <= {s_new.expiry, s_new.y, s_new.x, 8'(slot)};
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tuser <= res_status;
            m_tdata <= res_data;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `STG_ASSERT_NOW(a_no_take_in_clear, state == S_CLEAR, !s_tready)
  `STG_ASSERT_NEXT(a_busy_after_take, s_tvalid && s_tready, !s_tready)
  `STG_ASSERT_NOW(a_status_range, m_tvalid, m_tuser <= stg_pkg::ST_BAD_MOVE)
  `STG_ASSERT_NOW(a_fail_zero, m_tvalid && (m_tuser == stg_pkg::ST_SKEW ||
    m_tuser == stg_pkg::ST_REPLAY || m_tuser == stg_pkg::ST_FULL ||
    m_tuser == stg_pkg::ST_UNKNOWN), m_tdata == 88'd0)

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// Session table testbench
// Drives join, move and lookup requests into the session table under random
// idling on both streams. A behavioral copy of the table and the nonce ring
// predicts each result, and every result beat is compared field by field.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_SPARE  = 2'd3;
  localparam int NUM_SLOTS  = 256;
  localparam int NUM_NONCES = 512;
  localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [63:0] ONES64 = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  op;
    logic [47:0] now;
    logic [47:0] join_at;
    logic [63:0] nonce_hi;
    logic [63:0] nonce_lo;
    logic [63:0] tok_hi;
    logic [63:0] tok_lo;
    logic [63:0] seq;
    logic [7:0]  dx;
    logic [7:0]  dy;
  } request_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  slot;
    logic [15:0] x;
    logic [15:0] y;
    logic [47:0] expires;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [431:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [87:0] m_tdata;
  logic [2:0] m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  session_table_with_replay_guard DUT (.*);

  always #2 clk = ~clk;

  // Shadow copy of the table, the nonce ring and the registers.
  logic [31:0] skew_ms, ttl_ms;
  logic [14:0] pos_limit;
  logic        tbl_valid [NUM_SLOTS];
  logic [63:0] tbl_tok_hi [NUM_SLOTS];
  logic [63:0] tbl_tok_lo [NUM_SLOTS];
  logic [47:0] tbl_expiry [NUM_SLOTS];
  logic [63:0] tbl_seq [NUM_SLOTS];
  logic [15:0] tbl_x [NUM_SLOTS];
  logic [15:0] tbl_y [NUM_SLOTS];
  logic [7:0]  slot_cursor;
  logic        ring_valid [NUM_NONCES];
  logic [63:0] ring_hi [NUM_NONCES];
  logic [63:0] ring_lo [NUM_NONCES];
  logic [47:0] ring_expiry [NUM_NONCES];
  logic [8:0]  ring_cursor;

  outcome_t expected_outcomes[$];
  int errors = 0;
  bit quiet = 0;
  int stall_left = 0;

  // Random-phase token pool so that moves and lookups hit live sessions.
  logic [63:0] pool_hi [16];
  logic [63:0] pool_lo [16];
  logic [63:0] pool_seq [16];
  logic [63:0] recent_nonce_hi [8];
  logic [63:0] recent_nonce_lo [8];

  function automatic logic [47:0] expiry_after(logic [47:0] now, logic [31:0] life);
    logic [48:0] s;
    s = {1'b0, now} + {17'd0, life};
    return s > {1'b0, TIME_MAX} ? TIME_MAX : s[47:0];
  endfunction

  function automatic logic [15:0] step_clamped(logic [15:0] p, int d);
    int v;
    int lim;
    v = int'($signed(p)) + d;
    lim = int'(pos_limit);
    if (v < -lim) v = -lim;
    if (v > lim) v = lim;
    return v[15:0];
  endfunction

  function automatic outcome_t report_slot(logic [2:0] st, int s);
    outcome_t o;
    o = '0;
    o.status = st;
    if (s >= 0) begin
      o.slot = s[7:0];
      o.x = tbl_x[s];
      o.y = tbl_y[s];
      o.expires = tbl_expiry[s];
    end
    return o;
  endfunction

  function automatic outcome_t table_response(request_t r);
    logic [63:0] lo_b, hi_b;
    int s, k, dx, dy;
    s = -1;
    if (r.op == stg_pkg::OP_JOIN) begin
      lo_b = (r.now >= skew_ms) ? r.now - skew_ms : 64'd0;
      hi_b = 64'(r.now) + 64'(skew_ms);
      if (r.join_at < lo_b || r.join_at > hi_b) return report_slot(stg_pkg::ST_SKEW, -1);
      for (int i = 0; i < NUM_NONCES; i++)
        if (ring_valid[i] && ring_expiry[i] > r.now &&
            ring_hi[i] == r.nonce_hi && ring_lo[i] == r.nonce_lo)
          return report_slot(stg_pkg::ST_REPLAY, -1);
      ring_hi[ring_cursor] = r.nonce_hi;
      ring_lo[ring_cursor] = r.nonce_lo;
      ring_expiry[ring_cursor] = expiry_after(r.now, skew_ms);
      ring_valid[ring_cursor] = 1'b1;
      ring_cursor = ring_cursor + 9'd1;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        k = (int'(slot_cursor) + i) % NUM_SLOTS;
        if (!tbl_valid[k] || tbl_expiry[k] <= r.now) begin
          s = k;
          break;
        end
      end
      if (s < 0) return report_slot(stg_pkg::ST_FULL, -1);
      tbl_valid[s] = 1'b1;
      tbl_tok_hi[s] = r.tok_hi;
      tbl_tok_lo[s] = r.tok_lo;
      tbl_expiry[s] = expiry_after(r.now, ttl_ms);
      tbl_seq[s] = '0;
      tbl_x[s] = '0;
      tbl_y[s] = '0;
      slot_cursor = 8'(s + 1);
      return report_slot(stg_pkg::ST_OK, s);
    end
    // Lowest matching live slot wins when tokens are duplicated.
    for (int i = 0; i < NUM_SLOTS; i++)
      if (tbl_valid[i] && tbl_expiry[i] > r.now &&
          tbl_tok_hi[i] == r.tok_hi && tbl_tok_lo[i] == r.tok_lo) begin
        s = i;
        break;
      end
    if (s < 0) return report_slot(stg_pkg::ST_UNKNOWN, -1);
    if (r.op == stg_pkg::OP_MOVE) begin
      dx = int'($signed(r.dx));
      dy = int'($signed(r.dy));
      if (r.seq <= tbl_seq[s]) return report_slot(stg_pkg::ST_STALE, s);
      tbl_seq[s] = r.seq;
      tbl_expiry[s] = expiry_after(r.now, ttl_ms);
      if (dx < -1 || dx > 1 || dy < -1 || dy > 1)
        return report_slot(stg_pkg::ST_BAD_MOVE, s);
      tbl_x[s] = step_clamped(tbl_x[s], dx);
      tbl_y[s] = step_clamped(tbl_y[s], dy);
    end
    return report_slot(stg_pkg::ST_OK, s);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Result side: random back-pressure and field-by-field compare.
  always @(posedge clk) begin
    outcome_t want;
    if (m_tvalid && m_tready) begin
      if (expected_outcomes.size() == 0) begin
        report_mismatch("unexpected result beat", {61'd0, m_tuser}, '0);
      end else begin
        want = expected_outcomes.pop_front();
        if (m_tuser !== want.status)
          report_mismatch("status", 64'(m_tuser), 64'(want.status));
        if (m_tdata[7:0] !== want.slot)
          report_mismatch("session_slot", 64'(m_tdata[7:0]), 64'(want.slot));
        if (m_tdata[23:8] !== want.x)
          report_mismatch("pos_x", 64'(m_tdata[23:8]), 64'(want.x));
        if (m_tdata[39:24] !== want.y)
          report_mismatch("pos_y", 64'(m_tdata[39:24]), 64'(want.y));
        if (m_tdata[87:40] !== want.expires)
          report_mismatch("expires_at_ms", 64'(m_tdata[87:40]), 64'(want.expires));
      end
    end
    if (quiet || rst) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 13);
    end
  end

  task automatic send_request(request_t r);
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= r.op;
    s_tdata <= {r.dy, r.dx, r.seq, r.tok_lo, r.tok_hi, r.nonce_lo, r.nonce_hi,
                r.join_at, r.now};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_outcomes.push_back(table_response(r));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [31:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      stg_pkg::REG_SKEW:  skew_ms = value;
      stg_pkg::REG_TTL:   ttl_ms = value;
      stg_pkg::REG_LIMIT: pos_limit = value[14:0];
      default: ;
    endcase
  endtask

  function automatic request_t make_req(logic [1:0] op, logic [47:0] now, logic [47:0] jt,
                                        logic [63:0] nhi, logic [63:0] nlo, logic [63:0] thi,
                                        logic [63:0] tlo, logic [63:0] seq, logic [7:0] dx,
                                        logic [7:0] dy);
    request_t r;
    r = '{op, now, jt, nhi, nlo, thi, tlo, seq, dx, dy};
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed();
    logic [47:0] t;
    logic [63:0] ta, tb, tc;
    t = 48'd1_000_000;
    ta = 64'h1111; tb = 64'h2222; tc = 64'h3333;
    send_request(make_req(stg_pkg::OP_JOIN, t, t, 1, 1, ta, ta, 0, 0, 0));
    // Replayed nonce.
    send_request(make_req(stg_pkg::OP_JOIN, t, t, 1, 1, tb, tb, 0, 0, 0));
    send_request(make_req(stg_pkg::OP_JOIN, t, t + 30001, 2, 2, tb, tb, 0, 0, 0));
    send_request(make_req(stg_pkg::OP_JOIN, t, t - 30001, 2, 2, tb, tb, 0, 0, 0));
    send_request(make_req(stg_pkg::OP_JOIN, t, t - 30000, 2, 2, tb, tb, 0, 0, 0));
    // Lower skew bound would be negative here.
    send_request(make_req(stg_pkg::OP_JOIN, 100, 0, 3, 3, tc, tc, 0, 0, 0));
    send_request(make_req(stg_pkg::OP_MOVE, t, 0, 0, 0, ta, ta, 1, 8'sd1, 8'sd1));
    send_request(make_req(stg_pkg::OP_MOVE, t, 0, 0, 0, ta, ta, 1, 0, 0));
    send_request(make_req(stg_pkg::OP_MOVE, t, 0, 0, 0, ta, ta, 2, 8'sd1, -8'sd1));
    send_request(make_req(stg_pkg::OP_MOVE, t, 0, 0, 0, ta, ta, 3, 8'sd2, 0));
    send_request(make_req(stg_pkg::OP_MOVE, t + 1, 0, 0, 0, ta, ta, ONES64, 8'h80, 8'h7F));
    send_request(make_req(OP_LOOKUP, t + 2, 0, 0, 0, ta, ta, 0, 0, 0));
    send_request(make_req(OP_SPARE, t + 2, 0, 0, 0, ta, ta, 0, 0, 0));
    send_request(make_req(OP_LOOKUP, t, 0, 0, 0, ONES64, ONES64, 0, 0, 0));
    // Duplicate token.
    send_request(make_req(stg_pkg::OP_JOIN, t, t, 4, 4, ta, ta, 0, 0, 0));
    send_request(make_req(OP_LOOKUP, t, 0, 0, 0, ta, ta, 0, 0, 0));
    for (int i = 1; i <= 3; i++)
      send_request(make_req(stg_pkg::OP_MOVE, t + 10, 0, 0, 0, tb, tb, i, 8'sd1, -8'sd1));
    // Lowering the limit clamps the position on the next accepted move.
    write_register(stg_pkg::REG_LIMIT, 1);
    send_request(make_req(stg_pkg::OP_MOVE, t + 11, 0, 0, 0, tb, tb, 4, 0, 0));
    send_request(make_req(stg_pkg::OP_MOVE, t + 11 + 1_800_000, 0, 0, 0, tb, tb, 5, 0, 0));
    send_request(make_req(stg_pkg::OP_JOIN, TIME_MAX, TIME_MAX, ONES64, ONES64, ONES64,
                          ONES64, ONES64, 0, 0));
    send_request(make_req(stg_pkg::OP_MOVE, TIME_MAX - 1, 0, 0, 0, ONES64, ONES64, 7,
                          8'sd1, 8'sd1));
  endtask

  task automatic test_extreme_settings();
    logic [47:0] t;
    t = 48'd2_000_000;
    write_register(stg_pkg::REG_SKEW, 0);
    write_register(stg_pkg::REG_TTL, 1);
    write_register(stg_pkg::REG_LIMIT, 0);
    send_request(make_req(stg_pkg::OP_JOIN, t, t, 5, 5, 64'h4444, 1, 0, 0, 0));
    send_request(make_req(stg_pkg::OP_JOIN, t, t + 1, 6, 6, 64'h4444, 2, 0, 0, 0));
    send_request(make_req(stg_pkg::OP_MOVE, t, 0, 0, 0, 64'h4444, 1, 1, 8'sd1, -8'sd1));
    send_request(make_req(OP_LOOKUP, t + 1, 0, 0, 0, 64'h4444, 1, 0, 0, 0));
  endtask

  task automatic test_table_full();
    logic [47:0] t;
    logic [63:0] n;
    write_register(stg_pkg::REG_SKEW, 32'hFFFF_FFFF);
    write_register(stg_pkg::REG_TTL, 32'hFFFF_FFFF);
    write_register(stg_pkg::REG_LIMIT, 15'h7FFF);
    t = 48'd3_000_000;
    for (int i = 0; i < 262; i++) begin
      n = rand64();
      send_request(make_req(stg_pkg::OP_JOIN, t + i, (i % 2) ? 48'd0 : t + i, n, ~n,
                            rand64(), rand64(), 0, 0, 0));
    end
    // Nonce of a refused join stays recorded.
    send_request(make_req(stg_pkg::OP_JOIN, t + 300, t, n, ~n, 1, 1, 0, 0, 0));
  endtask

  task automatic random_phase(int count, logic [31:0] skew, logic [31:0] ttl,
                              logic [14:0] lim, bit last);
    logic [47:0] now;
    request_t r;
    int k, pick;
    write_register(stg_pkg::REG_SKEW, skew);
    write_register(stg_pkg::REG_TTL, ttl);
    write_register(stg_pkg::REG_LIMIT, lim);
    quiet = last;
    now = 48'd10_000_000_000 + 48'($urandom_range(0, 1_000_000));
    for (int i = 0; i < count; i++) begin
      now = now + 48'($urandom_range(0, ttl > 20000 ? 3000 : 200));
      k = $urandom_range(0, 15);
      pick = $urandom_range(0, 99);
      r = make_req(OP_LOOKUP, now, 0, rand64(), rand64(), pool_hi[k], pool_lo[k],
                   rand64(), 8'($urandom), 8'($urandom));
      if (pick < 35) begin
        r.op = stg_pkg::OP_JOIN;
        r.join_at = now + 48'($urandom_range(0, skew > 1000 ? 1000 : skew))
                    - 48'($urandom_range(0, skew > 1000 ? 1000 : skew));
        if ($urandom_range(0, 9) == 0) r.join_at = 48'({$urandom, $urandom});
        if ($urandom_range(0, 5) == 0) begin
          r.nonce_hi = recent_nonce_hi[$urandom_range(0, 7)];
          r.nonce_lo = recent_nonce_lo[$urandom_range(0, 7)];
        end
        recent_nonce_hi[i % 8] = r.nonce_hi;
        recent_nonce_lo[i % 8] = r.nonce_lo;
        if ($urandom_range(0, 3) == 0) begin
          pool_hi[k] = rand64();
          pool_lo[k] = rand64();
          r.tok_hi = pool_hi[k];
          r.tok_lo = pool_lo[k];
        end
        pool_seq[k] = 0;
      end else if (pick < 85) begin
        r.op = stg_pkg::OP_MOVE;
        if ($urandom_range(0, 9) != 0) begin
          r.seq = pool_seq[k] + 64'($urandom_range(0, 3));
          r.dx = 8'($signed($urandom_range(0, 2)) - 1);
          r.dy = 8'($signed($urandom_range(0, 2)) - 1);
          if ($urandom_range(0, 9) == 0) r.dx = 8'($urandom);
          if (r.seq > pool_seq[k]) pool_seq[k] = r.seq;
        end
      end else if (pick < 95) begin
        r.op = OP_LOOKUP;
      end else begin
        r.op = OP_SPARE;
      end
      if ($urandom_range(0, 30) == 0) r.now = 48'({$urandom, $urandom});
      if ($urandom_range(0, 20) == 0) r.tok_lo = rand64();
      send_request(r);
    end
  endtask

  initial begin
    skew_ms = stg_pkg::SKEW_RESET;
    ttl_ms = stg_pkg::TTL_RESET;
    pos_limit = stg_pkg::LIMIT_RESET;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      tbl_valid[i] = 0; tbl_tok_hi[i] = 0; tbl_tok_lo[i] = 0;
      tbl_expiry[i] = 0; tbl_seq[i] = 0; tbl_x[i] = 0; tbl_y[i] = 0;
    end
    for (int i = 0; i < NUM_NONCES; i++) begin
      ring_valid[i] = 0; ring_hi[i] = 0; ring_lo[i] = 0; ring_expiry[i] = 0;
    end
    slot_cursor = 0;
    ring_cursor = 0;
    for (int i = 0; i < 16; i++) begin
      pool_hi[i] = rand64(); pool_lo[i] = rand64(); pool_seq[i] = 0;
    end
    for (int i = 0; i < 8; i++) begin
      recent_nonce_hi[i] = rand64(); recent_nonce_lo[i] = rand64();
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_extreme_settings();
    test_table_full();
    random_phase(140, 5000, 20000, 3, 0);
    random_phase(80, 0, 4000, 0, 0);
    random_phase(140, 32'hFFFF_FFFF, 50000, 15'h7FFF, 0);
    random_phase(100, 2000, 9000, 2, 1);
    wait_drained();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/stg_pkg.sv
hw/rtl/stg_ram.sv
hw/rtl/session_table_with_replay_guard.sv
bench/tb_top.sv
